FILE: design/psc_pkg.sv
// psc_pkg: shared types and constants for the pressure sensor compensation block
// no dependencies; used by psc_csr and pressure_sensor_compensation

package psc_pkg;

   localparam int RAW_W       = 24;
   localparam int CAL_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int PA_W        = 23;
   localparam int TC_W        = 15;
   localparam int TW_W        = 8;

   // register stages from accept to result
   localparam int PIPE_DEPTH  = 12;

   // calibration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPERATURE_SLOPE      = 3'd5;

   // output limits
   localparam int P_MIN  = -1000000;
   localparam int P_MAX  = 4000000;
   localparam int TC_MIN = -4000;
   localparam int TC_MAX = 8500;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sensitivity_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temperature_slope;
   } cal_type;

endpackage

FILE: design/psc_csr.sv
// psc_csr: calibration register file written through the csr channel
// depends on psc_pkg for the register indexes and the cal_type struct

module psc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psc_pkg::CAL_W-1:0]         csr_wdata,
   output psc_pkg::cal_type                  cal
);
   import psc_pkg::*;

   cal_type cal_ff, cal_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign cal       = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (wr) begin
         case (csr_index)
            REG_PRESSURE_SENSITIVITY:   cal_in.pressure_sensitivity   = csr_wdata;
            REG_PRESSURE_OFFSET:        cal_in.pressure_offset        = csr_wdata;
            REG_SENSITIVITY_TEMP_COEFF: cal_in.sensitivity_temp_coeff = csr_wdata;
            REG_OFFSET_TEMP_COEFF:      cal_in.offset_temp_coeff      = csr_wdata;
            REG_REFERENCE_TEMPERATURE:  cal_in.reference_temperature  = csr_wdata;
            REG_TEMPERATURE_SLOPE:      cal_in.temperature_slope      = csr_wdata;
            default:                    cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

`ifndef ASSERT_OFF
   a_write_sens: assert property (@(posedge clock) disable iff (reset)
      wr && csr_index == REG_PRESSURE_SENSITIVITY
      |=> cal_ff.pressure_sensitivity == $past(csr_wdata))
      else $error("sensitivity write not taken");

   a_write_slope: assert property (@(posedge clock) disable iff (reset)
      wr && csr_index == REG_TEMPERATURE_SLOPE
      |=> cal_ff.temperature_slope == $past(csr_wdata))
      else $error("slope write not taken");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !wr |=> $stable(cal_ff))
      else $error("calibration changed without a write");
`endif

endmodule

FILE: design/pressure_sensor_compensation.sv
// pressure_sensor_compensation: pipelined second-order barometric compensation
// depends on psc_pkg and psc_csr

// One item (a raw pressure and a raw temperature conversion) is accepted on
// every clock at which start is high; busy stays low. The result comes out
// with rsp_valid once its item has passed every register stage, for one cycle,
// and must be taken then. A new item every cycle is sustained, set by the
// fully pipelined datapath; the pipeline depth is set by the pressure path
// (sensitivity and offset, then the 24 x 39 bit product split into two halves,
// then the two truncating shifts). Calibration words must be written through
// the csr channel only while no item is in flight (not enforced by the block)
// and apply to items accepted after the write. No clearing pass after reset.

module pressure_sensor_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic        [psc_pkg::RAW_W-1:0]       req_raw_pressure,
   input  logic        [psc_pkg::RAW_W-1:0]       req_raw_temperature,
   output logic                                  rsp_valid,
   output logic signed [psc_pkg::PA_W-1:0]        rsp_pressure_pa,
   output logic signed [psc_pkg::TC_W-1:0]        rsp_temperature_centi,
   output logic signed [psc_pkg::TW_W-1:0]        rsp_temperature_whole,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [psc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [psc_pkg::CAL_W-1:0]       csr_wdata
);
   import psc_pkg::*;

   cal_type cal;
   logic    accept;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   // stage 1
   logic signed [24:0] s1_dt_ff, s1_dt_in;
   logic        [23:0] s1_d1_ff;
   // stage 2
   logic signed [41:0] s2_mt_ff, s2_mt_in;
   logic signed [41:0] s2_moff_ff, s2_moff_in;
   logic signed [41:0] s2_msens_ff, s2_msens_in;
   logic signed [49:0] dd_full;
   logic        [48:0] s2_dd_ff, s2_dd_in;
   logic        [23:0] s2_d1_ff;
   // stage 3
   logic signed [41:0] t_bias, off_bias, sens_bias;
   logic        [34:0] off_div;
   logic        [33:0] sens_div;
   logic        [50:0] dd3;
   logic signed [17:0] s3_dtemp_ff, s3_dtemp_in;
   logic signed [39:0] s3_off_ff, s3_off_in;
   logic signed [38:0] s3_sens_ff, s3_sens_in;
   logic        [16:0] s3_ti_ff, s3_ti_in;
   logic        [23:0] s3_d1_ff;
   // stage 4
   logic signed [35:0] sq_full;
   logic signed [18:0] v;
   logic signed [37:0] vv_full;
   logic        [34:0] s4_sq_ff, s4_sq_in;
   logic        [34:0] s4_vv_ff, s4_vv_in;
   logic               s4_low_ff, s4_low_in;
   logic               s4_vlow_ff, s4_vlow_in;
   logic signed [19:0] s4_tc_ff, s4_tc_in;
   logic signed [39:0] s4_off_ff;
   logic signed [38:0] s4_sens_ff;
   logic        [23:0] s4_d1_ff;
   // stage 5
   logic        [36:0] sq3;
   logic        [37:0] sq5, vv7;
   logic        [38:0] s5_offi_ff, s5_offi_in;
   logic        [37:0] s5_sensi_ff, s5_sensi_in;
   logic signed [14:0] s5_tcc_ff, s5_tcc_in;
   logic signed [39:0] s5_off_ff;
   logic signed [38:0] s5_sens_ff;
   logic        [23:0] s5_d1_ff;
   // stage 6
   logic signed [14:0] tc_neg;
   logic        [13:0] tc_mag;
   logic signed [39:0] s6_off2_ff, s6_off2_in;
   logic signed [38:0] s6_sens2_ff, s6_sens2_in;
   logic        [26:0] s6_twp_ff, s6_twp_in;
   logic               s6_twneg_ff;
   logic signed [14:0] s6_tcc_ff;
   logic        [23:0] s6_d1_ff;
   // stage 7
   logic        [7:0]  tw_q;
   logic        [43:0] s7_pl_ff, s7_pl_in;
   logic signed [43:0] s7_ph_ff, s7_ph_in;
   logic signed [39:0] s7_off2_ff;
   logic signed [14:0] s7_tcc_ff;
   logic signed [7:0]  s7_tw_ff, s7_tw_in;
   // stage 8
   logic signed [63:0] s8_prod_ff, s8_prod_in;
   logic signed [39:0] s8_off2_ff;
   logic signed [14:0] s8_tcc_ff;
   logic signed [7:0]  s8_tw_ff;
   // stage 9
   logic signed [63:0] prod_bias;
   logic signed [42:0] s9_x_ff, s9_x_in;
   logic signed [39:0] s9_off2_ff;
   logic signed [14:0] s9_tcc_ff;
   logic signed [7:0]  s9_tw_ff;
   // stage 10
   logic signed [43:0] s10_y_ff, s10_y_in;
   logic signed [14:0] s10_tcc_ff;
   logic signed [7:0]  s10_tw_ff;
   // stage 11
   logic signed [43:0] y_bias;
   logic signed [30:0] s11_p_ff, s11_p_in;
   logic signed [14:0] s11_tcc_ff;
   logic signed [7:0]  s11_tw_ff;
   // output stage
   logic signed [34:0] p_ext, p10;
   logic signed [22:0] out_pa_ff, out_pa_in;
   logic signed [14:0] out_tc_ff;
   logic signed [7:0]  out_tw_ff;

   psc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cal       (cal)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], accept};

   // stage 1: temperature difference
   assign s1_dt_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'b0});

   // stage 2: products of dt
   assign s2_mt_in    = s1_dt_ff * $signed({1'b0, cal.temperature_slope});
   assign s2_moff_in  = s1_dt_ff * $signed({1'b0, cal.offset_temp_coeff});
   assign s2_msens_in = s1_dt_ff * $signed({1'b0, cal.sensitivity_temp_coeff});
   assign dd_full     = s1_dt_ff * s1_dt_ff;
   assign s2_dd_in    = dd_full[48:0];

   // stage 3: first-order terms, divisions rounded toward zero
   assign t_bias    = s2_mt_ff + (s2_mt_ff[41] ? 42'sd8388607 : 42'sd0);
   assign s3_dtemp_in = t_bias[40:23];
   assign off_bias  = s2_moff_ff + (s2_moff_ff[41] ? 42'sd127 : 42'sd0);
   assign off_div   = off_bias[41:7];
   assign sens_bias = s2_msens_ff + (s2_msens_ff[41] ? 42'sd255 : 42'sd0);
   assign sens_div  = sens_bias[41:8];
   assign s3_off_in  = $signed({8'b0, cal.pressure_offset, 16'b0})
                     + $signed({{5{off_div[34]}}, off_div});
   assign s3_sens_in = $signed({8'b0, cal.pressure_sensitivity, 15'b0})
                     + $signed({{5{sens_div[33]}}, sens_div});
   assign dd3       = {2'b0, s2_dd_ff} + {1'b0, s2_dd_ff, 1'b0};
   // low branch 3*dt^2 / 2^33, high branch 2*dt^2 / 2^37
   assign s3_ti_in  = s3_dtemp_in[17] ? dd3[49:33] : {4'b0, s2_dd_ff[48:36]};

   // stage 4: squares and corrected temperature
   assign sq_full    = s3_dtemp_ff * s3_dtemp_ff;
   assign s4_sq_in   = sq_full[34:0];
   assign v          = $signed({s3_dtemp_ff[17], s3_dtemp_ff}) + 19'sd3500;
   assign vv_full    = v * v;
   assign s4_vv_in   = vv_full[34:0];
   assign s4_low_in  = s3_dtemp_ff[17];
   assign s4_vlow_in = s3_dtemp_ff < -18'sd3500;
   assign s4_tc_in   = $signed({{2{s3_dtemp_ff[17]}}, s3_dtemp_ff}) + 20'sd2000
                     - $signed({3'b0, s3_ti_ff});

   // stage 5: second-order offset and sensitivity terms, temperature clamp
   assign sq3 = {2'b0, s4_sq_ff} + {1'b0, s4_sq_ff, 1'b0};
   assign sq5 = {3'b0, s4_sq_ff} + {1'b0, s4_sq_ff, 2'b0};
   assign vv7 = {s4_vv_ff, 3'b0} - {3'b0, s4_vv_ff};

   always_comb begin
      if (s4_low_ff) begin
         s5_offi_in  = {3'b0, sq3[36:1]} + (s4_vlow_ff ? {1'b0, vv7} : 39'd0);
         s5_sensi_in = {3'b0, sq5[37:3]} + (s4_vlow_ff ? {1'b0, s4_vv_ff, 2'b0} : 38'd0);
      end else begin
         s5_offi_in  = {8'b0, s4_sq_ff[34:4]};
         s5_sensi_in = 38'd0;
      end
      if (s4_tc_ff < TC_MIN) begin
         s5_tcc_in = 15'(TC_MIN);
      end else if (s4_tc_ff > TC_MAX) begin
         s5_tcc_in = 15'(TC_MAX);
      end else begin
         s5_tcc_in = s4_tc_ff[14:0];
      end
   end

   // stage 6: corrected offset and sensitivity; whole degrees via 5243 / 2^19
   assign s6_off2_in  = s5_off_ff - $signed({1'b0, s5_offi_ff});
   assign s6_sens2_in = s5_sens_ff - $signed({1'b0, s5_sensi_ff});
   assign tc_neg      = -s5_tcc_ff;
   assign tc_mag      = s5_tcc_ff[14] ? tc_neg[13:0] : s5_tcc_ff[13:0];
   assign s6_twp_in   = {13'b0, tc_mag} * 27'd5243;

   // stage 7: d1 * sens in two halves
   assign s7_pl_in = s6_d1_ff * s6_sens2_ff[19:0];
   assign s7_ph_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens2_ff[38:20]);
   assign tw_q     = s6_twp_ff[26:19];
   assign s7_tw_in = s6_twneg_ff ? (8'd0 - tw_q) : tw_q;

   // stage 8: recombine the halves
   assign s8_prod_in = ($signed({{20{s7_ph_ff[43]}}, s7_ph_ff}) <<< 20)
                     + $signed({20'b0, s7_pl_ff});

   // stage 9: / 2^21 toward zero
   assign prod_bias = s8_prod_ff + (s8_prod_ff[63] ? 64'sd2097151 : 64'sd0);
   assign s9_x_in   = prod_bias[63:21];

   // stage 10: subtract offset
   assign s10_y_in = $signed({s9_x_ff[42], s9_x_ff})
                   - $signed({{4{s9_off2_ff[39]}}, s9_off2_ff});

   // stage 11: / 8192 toward zero
   assign y_bias   = s10_y_ff + (s10_y_ff[43] ? 44'sd8191 : 44'sd0);
   assign s11_p_in = y_bias[43:13];

   // output stage: 0.1 mbar to pascal and clamp
   assign p_ext = $signed({{4{s11_p_ff[30]}}, s11_p_ff});
   assign p10   = (p_ext <<< 3) + (p_ext <<< 1);

   always_comb begin
      if (p10 < P_MIN) begin
         out_pa_in = 23'(P_MIN);
      end else if (p10 > P_MAX) begin
         out_pa_in = 23'(P_MAX);
      end else begin
         out_pa_in = p10[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dt_ff    <= s1_dt_in;
      s1_d1_ff    <= req_raw_pressure;

      s2_mt_ff    <= s2_mt_in;
      s2_moff_ff  <= s2_moff_in;
      s2_msens_ff <= s2_msens_in;
      s2_dd_ff    <= s2_dd_in;
      s2_d1_ff    <= s1_d1_ff;

      s3_dtemp_ff <= s3_dtemp_in;
      s3_off_ff   <= s3_off_in;
      s3_sens_ff  <= s3_sens_in;
      s3_ti_ff    <= s3_ti_in;
      s3_d1_ff    <= s2_d1_ff;

      s4_sq_ff    <= s4_sq_in;
      s4_vv_ff    <= s4_vv_in;
      s4_low_ff   <= s4_low_in;
      s4_vlow_ff  <= s4_vlow_in;
      s4_tc_ff    <= s4_tc_in;
      s4_off_ff   <= s3_off_ff;
      s4_sens_ff  <= s3_sens_ff;
      s4_d1_ff    <= s3_d1_ff;

      s5_offi_ff  <= s5_offi_in;
      s5_sensi_ff <= s5_sensi_in;
      s5_tcc_ff   <= s5_tcc_in;
      s5_off_ff   <= s4_off_ff;
      s5_sens_ff  <= s4_sens_ff;
      s5_d1_ff    <= s4_d1_ff;

      s6_off2_ff  <= s6_off2_in;
      s6_sens2_ff <= s6_sens2_in;
      s6_twp_ff   <= s6_twp_in;
      s6_twneg_ff <= s5_tcc_ff[14];
      s6_tcc_ff   <= s5_tcc_ff;
      s6_d1_ff    <= s5_d1_ff;

      s7_pl_ff    <= s7_pl_in;
      s7_ph_ff    <= s7_ph_in;
      s7_off2_ff  <= s6_off2_ff;
      s7_tcc_ff   <= s6_tcc_ff;
      s7_tw_ff    <= s7_tw_in;

      s8_prod_ff  <= s8_prod_in;
      s8_off2_ff  <= s7_off2_ff;
      s8_tcc_ff   <= s7_tcc_ff;
      s8_tw_ff    <= s7_tw_ff;

      s9_x_ff     <= s9_x_in;
      s9_off2_ff  <= s8_off2_ff;
      s9_tcc_ff   <= s8_tcc_ff;
      s9_tw_ff    <= s8_tw_ff;

      s10_y_ff    <= s10_y_in;
      s10_tcc_ff  <= s9_tcc_ff;
      s10_tw_ff   <= s9_tw_ff;

      s11_p_ff    <= s11_p_in;
      s11_tcc_ff  <= s10_tcc_ff;
      s11_tw_ff   <= s10_tw_ff;

      out_pa_ff   <= out_pa_in;
      out_tc_ff   <= s11_tcc_ff;
      out_tw_ff   <= s11_tw_ff;
   end

   assign rsp_valid             = vld_ff[PIPE_DEPTH-1];
   assign rsp_pressure_pa       = out_pa_ff;
   assign rsp_temperature_centi = out_tc_ff;
   assign rsp_temperature_whole = out_tw_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a matching item");

   a_pa_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pressure_pa >= P_MIN && rsp_pressure_pa <= P_MAX))
      else $error("pressure outside its clamp range");

   a_temp_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_temperature_whole != 8'sd0
      |-> rsp_temperature_whole[7] == rsp_temperature_centi[14])
      else $error("whole and centi temperature disagree in sign");
`endif

endmodule
